FILE: hdl/lofsw_pkg.sv
package lofsw_pkg;

    localparam int ALPHABET_SIZE = 26;
    localparam int MAX_WORD_LEN  = 32;
    localparam int MAX_WORDS     = 1024;

    localparam int LETTER_W = 5;
    localparam int POS_W    = $clog2(MAX_WORD_LEN + 1);
    localparam int PW_AW    = $clog2(MAX_WORD_LEN);
    localparam int WCNT_W   = $clog2(MAX_WORDS + 1);
    localparam int DEG_W    = 10;
    localparam int EDGE_W   = 11;
    localparam int EDGE_AW  = 2 * LETTER_W;

    localparam logic [LETTER_W-1:0] NUM_LETTERS = LETTER_W'(ALPHABET_SIZE);
    localparam logic [LETTER_W-1:0] LAST_LETTER = LETTER_W'(ALPHABET_SIZE - 1);
    localparam logic [POS_W-1:0]    MAX_POS     = POS_W'(MAX_WORD_LEN);
    localparam logic [WCNT_W-1:0]   WCNT_MAX    = WCNT_W'(MAX_WORDS);

    typedef logic [LETTER_W-1:0] letter_t;

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_CMP      = 14'b00000000000010,
        S_INC      = 14'b00000000000100,
        S_WEND     = 14'b00000000001000,
        S_SCAN_RD  = 14'b00000000010000,
        S_SCAN_CHK = 14'b00000000100000,
        S_POP_RD   = 14'b00000001000000,
        S_POP      = 14'b00000010000000,
        S_V_RD     = 14'b00000100000000,
        S_V_CHK    = 14'b00001000000000,
        S_EM_RD    = 14'b00010000000000,
        S_EM       = 14'b00100000000000,
        S_FAIL     = 14'b01000000000000,
        S_CLR      = 14'b10000000000000
    } state_t;

endpackage

FILE: hdl/lofsw_ram.sv
module lofsw_ram #(
    parameter int AW = 5,
    parameter int DW = 5
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/letter_order_from_sorted_words.sv
// Letter order from a sorted word list.
// Input channel: a word (one letter with its word_done and list_done marks)
// is taken at a rising edge where start is high and busy is low. Each word
// of the list ends with word_done; the last letter of the list carries
// list_done, which also ends the current word.
// A plain letter passes through S_CMP, one that records a precedence edge
// also through S_INC, and one that ends a word also through S_WEND; the
// split follows the registered reads of the previous-word, edge and
// in-degree memories. At list end the block runs a topological sort: an
// in-degree scan over every letter, then a check of every pair of popped
// letter and candidate successor, before the first result.
// Output channel: each result word is shown on order_letter, final_res and
// failed, marked by valid for exactly one cycle; results never come back to
// back and the receiver cannot hold them off. A failed list gives one
// result with failed and final_res set and order_letter zero.
// After the results, and after reset, a clearing pass zeroes the edge and
// in-degree memories; busy stays high throughout it.
module letter_order_from_sorted_words (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [4:0] letter,
    input  logic       word_done,
    input  logic       list_done,
    output logic       valid,
    output logic [4:0] order_letter,
    output logic       final_res,
    output logic       failed
);

    localparam int LW = lofsw_pkg::LETTER_W;
    localparam int PW = lofsw_pkg::POS_W;
    localparam int AW = lofsw_pkg::EDGE_AW;
    localparam int DW = lofsw_pkg::DEG_W;
    localparam int EW = lofsw_pkg::EDGE_W;
    localparam int CW = lofsw_pkg::WCNT_W;

    lofsw_pkg::state_t state_reg, state_next;

    // List state held in registers.
    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] plen_reg, plen_next;
    logic          diff_reg, diff_next;
    logic          first_reg, first_next;
    logic [lofsw_pkg::ALPHABET_SIZE-1:0] seen_reg, seen_next;
    logic [CW-1:0] wcnt_reg, wcnt_next;
    logic          fail_reg, fail_next;

    // The word being worked on.
    logic [LW-1:0] l_reg, l_next;
    logic          wd_reg, wd_next;
    logic          ld_reg, ld_next;
    logic [LW-1:0] p_reg, p_next;

    // Sort bookkeeping.
    logic [LW-1:0] u_reg, u_next;
    logic [LW-1:0] v_reg, v_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic [LW-1:0] head_reg, head_next;
    logic [LW-1:0] tail_reg, tail_next;
    logic [LW-1:0] scnt_reg, scnt_next;
    logic [AW-1:0] cidx_reg, cidx_next;

    logic          valid_reg, valid_next;
    logic [LW-1:0] ol_reg, ol_next;
    logic          fr_reg, fr_next;
    logic          fd_reg, fd_next;

    // Memory ports.
    logic                          pw_we;
    logic [lofsw_pkg::PW_AW-1:0]   pw_waddr, pw_raddr;
    logic [LW-1:0]                 pw_wdata, pw_rdata;
    logic                          ed_we;
    logic [AW-1:0]                 ed_waddr, ed_raddr;
    logic [EW-1:0]                 ed_wdata, ed_rdata;
    logic                          dg_we;
    logic [LW-1:0]                 dg_waddr, dg_raddr;
    logic [DW-1:0]                 dg_wdata, dg_rdata;
    logic                          q_we;
    logic [LW-1:0]                 q_waddr, q_raddr;
    logic [LW-1:0]                 q_wdata, q_rdata;

    logic          ends_word;
    logic          edge_hit;
    logic          bad_letter;
    logic          wend_fail;
    logic [DW-1:0] new_deg;

    lofsw_ram #(.AW(lofsw_pkg::PW_AW), .DW(LW)) u_prev_word (
        .clk(clk), .we(pw_we), .waddr(pw_waddr), .wdata(pw_wdata),
        .raddr(pw_raddr), .rdata(pw_rdata)
    );

    lofsw_ram #(.AW(AW), .DW(EW)) u_edge_count (
        .clk(clk), .we(ed_we), .waddr(ed_waddr), .wdata(ed_wdata),
        .raddr(ed_raddr), .rdata(ed_rdata)
    );

    lofsw_ram #(.AW(LW), .DW(DW)) u_in_degree (
        .clk(clk), .we(dg_we), .waddr(dg_waddr), .wdata(dg_wdata),
        .raddr(dg_raddr), .rdata(dg_rdata)
    );

    lofsw_ram #(.AW(LW), .DW(LW)) u_ready_queue (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    assign busy         = (state_reg != lofsw_pkg::S_IDLE);
    assign valid        = valid_reg;
    assign order_letter = ol_reg;
    assign final_res    = fr_reg;
    assign failed       = fd_reg;

    assign ends_word  = wd_reg | ld_reg;
    assign bad_letter = (letter >= lofsw_pkg::NUM_LETTERS) || (pos_reg >= lofsw_pkg::MAX_POS);

    // A new edge is recorded at the first position where this word departs
    // from the previous one.
    assign edge_hit = !fail_reg && !first_reg && !diff_reg && (pos_reg < plen_reg)
                      && (pw_rdata != l_reg) && (pw_rdata < lofsw_pkg::NUM_LETTERS);

    // A word that is a strict prefix of its predecessor breaks the order.
    assign wend_fail = !first_reg && !diff_reg && (plen_reg > pos_reg);

    // The in-degree never drops below zero; a larger edge count clears it.
    assign new_deg = (ed_rdata >= {1'b0, dg_rdata}) ? '0 : (dg_rdata - ed_rdata[DW-1:0]);

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        plen_next  = plen_reg;
        diff_next  = diff_reg;
        first_next = first_reg;
        seen_next  = seen_reg;
        wcnt_next  = wcnt_reg;
        fail_next  = fail_reg;
        l_next     = l_reg;
        wd_next    = wd_reg;
        ld_next    = ld_reg;
        p_next     = p_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        idx_next   = idx_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        scnt_next  = scnt_reg;
        cidx_next  = cidx_reg;
        valid_next = 1'b0;
        ol_next    = ol_reg;
        fr_next    = fr_reg;
        fd_next    = fd_reg;

        pw_we    = 1'b0;
        pw_waddr = pos_reg[lofsw_pkg::PW_AW-1:0];
        pw_wdata = l_reg;
        pw_raddr = pos_reg[lofsw_pkg::PW_AW-1:0];
        ed_we    = 1'b0;
        ed_waddr = {p_reg, l_reg};
        ed_wdata = ed_rdata + EW'(1);
        ed_raddr = {u_reg, v_reg};
        dg_we    = 1'b0;
        dg_waddr = l_reg;
        dg_wdata = dg_rdata + DW'(1);
        dg_raddr = v_reg;
        q_we     = 1'b0;
        q_waddr  = tail_reg;
        q_wdata  = v_reg;
        q_raddr  = head_reg;

        unique case (state_reg)
            lofsw_pkg::S_IDLE:
            begin
                if (start)
                begin
                    l_next  = letter;
                    wd_next = word_done;
                    ld_next = list_done;
                    if (bad_letter)
                    begin
                        fail_next  = 1'b1;
                        state_next = (word_done || list_done) ? lofsw_pkg::S_WEND
                                                              : lofsw_pkg::S_IDLE;
                    end
                    else
                    begin
                        seen_next[letter] = 1'b1;
                        state_next = lofsw_pkg::S_CMP;
                    end
                end
            end

            lofsw_pkg::S_CMP:
            begin
                pw_we    = 1'b1;
                pos_next = pos_reg + PW'(1);
                ed_raddr = {pw_rdata, l_reg};
                dg_raddr = l_reg;
                if (edge_hit)
                begin
                    diff_next  = 1'b1;
                    p_next     = pw_rdata;
                    state_next = lofsw_pkg::S_INC;
                end
                else
                begin
                    state_next = ends_word ? lofsw_pkg::S_WEND : lofsw_pkg::S_IDLE;
                end
            end

            lofsw_pkg::S_INC:
            begin
                ed_we      = 1'b1;
                dg_we      = 1'b1;
                state_next = ends_word ? lofsw_pkg::S_WEND : lofsw_pkg::S_IDLE;
            end

            lofsw_pkg::S_WEND:
            begin
                fail_next = fail_reg | wend_fail;
                if (wcnt_reg < lofsw_pkg::WCNT_MAX)
                begin
                    wcnt_next = wcnt_reg + CW'(1);
                end
                else
                begin
                    fail_next = 1'b1;
                end
                plen_next  = pos_reg;
                pos_next   = '0;
                diff_next  = 1'b0;
                first_next = 1'b0;
                idx_next   = '0;
                head_next  = '0;
                tail_next  = '0;
                scnt_next  = '0;
                if (!ld_reg)
                begin
                    state_next = lofsw_pkg::S_IDLE;
                end
                else if (fail_next)
                begin
                    state_next = lofsw_pkg::S_FAIL;
                end
                else
                begin
                    state_next = lofsw_pkg::S_SCAN_RD;
                end
            end

            lofsw_pkg::S_SCAN_RD:
            begin
                dg_raddr   = idx_reg;
                state_next = lofsw_pkg::S_SCAN_CHK;
            end

            lofsw_pkg::S_SCAN_CHK:
            begin
                if (seen_reg[idx_reg])
                begin
                    scnt_next = scnt_reg + LW'(1);
                    if (dg_rdata == '0 && tail_reg < lofsw_pkg::NUM_LETTERS)
                    begin
                        q_we      = 1'b1;
                        q_wdata   = idx_reg;
                        tail_next = tail_reg + LW'(1);
                    end
                end
                idx_next   = idx_reg + LW'(1);
                state_next = (idx_reg == lofsw_pkg::LAST_LETTER) ? lofsw_pkg::S_POP_RD
                                                                 : lofsw_pkg::S_SCAN_RD;
            end

            lofsw_pkg::S_POP_RD:
            begin
                q_raddr = head_reg;
                idx_next = '0;
                if (head_reg != tail_reg)
                begin
                    state_next = lofsw_pkg::S_POP;
                end
                else if (head_reg == scnt_reg && head_reg != '0)
                begin
                    state_next = lofsw_pkg::S_EM_RD;
                end
                else
                begin
                    // Some letters never became free: the graph has a cycle.
                    state_next = lofsw_pkg::S_FAIL;
                end
            end

            lofsw_pkg::S_POP:
            begin
                u_next     = q_rdata;
                head_next  = head_reg + LW'(1);
                v_next     = '0;
                state_next = lofsw_pkg::S_V_RD;
            end

            lofsw_pkg::S_V_RD:
            begin
                ed_raddr   = {u_reg, v_reg};
                dg_raddr   = v_reg;
                state_next = lofsw_pkg::S_V_CHK;
            end

            lofsw_pkg::S_V_CHK:
            begin
                if (ed_rdata != '0 && dg_rdata != '0)
                begin
                    dg_we    = 1'b1;
                    dg_waddr = v_reg;
                    dg_wdata = new_deg;
                    if (new_deg == '0 && tail_reg < lofsw_pkg::NUM_LETTERS)
                    begin
                        q_we      = 1'b1;
                        q_wdata   = v_reg;
                        tail_next = tail_reg + LW'(1);
                    end
                end
                v_next     = v_reg + LW'(1);
                state_next = (v_reg == lofsw_pkg::LAST_LETTER) ? lofsw_pkg::S_POP_RD
                                                               : lofsw_pkg::S_V_RD;
            end

            lofsw_pkg::S_EM_RD:
            begin
                q_raddr    = idx_reg;
                state_next = lofsw_pkg::S_EM;
            end

            lofsw_pkg::S_EM:
            begin
                valid_next = 1'b1;
                ol_next    = q_rdata;
                fd_next    = 1'b0;
                fr_next    = (idx_reg == head_reg - LW'(1));
                idx_next   = idx_reg + LW'(1);
                cidx_next  = '0;
                state_next = fr_next ? lofsw_pkg::S_CLR : lofsw_pkg::S_EM_RD;
            end

            lofsw_pkg::S_FAIL:
            begin
                valid_next = 1'b1;
                ol_next    = '0;
                fr_next    = 1'b1;
                fd_next    = 1'b1;
                cidx_next  = '0;
                state_next = lofsw_pkg::S_CLR;
            end

            lofsw_pkg::S_CLR:
            begin
                ed_we      = 1'b1;
                ed_waddr   = cidx_reg;
                ed_wdata   = '0;
                dg_we      = 1'b1;
                dg_waddr   = cidx_reg[LW-1:0];
                dg_wdata   = '0;
                pos_next   = '0;
                plen_next  = '0;
                diff_next  = 1'b0;
                first_next = 1'b1;
                seen_next  = '0;
                wcnt_next  = '0;
                fail_next  = 1'b0;
                cidx_next  = cidx_reg + AW'(1);
                state_next = (cidx_reg == '1) ? lofsw_pkg::S_IDLE : lofsw_pkg::S_CLR;
            end

            default:
            begin
                state_next = lofsw_pkg::S_CLR;
                cidx_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lofsw_pkg::S_CLR;
            cidx_reg  <= '0;
            pos_reg   <= '0;
            plen_reg  <= '0;
            diff_reg  <= 1'b0;
            first_reg <= 1'b1;
            seen_reg  <= '0;
            wcnt_reg  <= '0;
            fail_reg  <= 1'b0;
            head_reg  <= '0;
            tail_reg  <= '0;
            scnt_reg  <= '0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cidx_reg  <= cidx_next;
            pos_reg   <= pos_next;
            plen_reg  <= plen_next;
            diff_reg  <= diff_next;
            first_reg <= first_next;
            seen_reg  <= seen_next;
            wcnt_reg  <= wcnt_next;
            fail_reg  <= fail_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            scnt_reg  <= scnt_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg  <= l_next;
        wd_reg <= wd_next;
        ld_reg <= ld_next;
        p_reg  <= p_next;
        u_reg  <= u_next;
        v_reg  <= v_next;
        ol_reg <= ol_next;
        fr_reg <= fr_next;
        fd_reg <= fd_next;
    end

    // Results appear only while the block is busy with a list.
    a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> busy)
        else $error("result strobe while idle");

    // A failure result is always the single, final result of its list.
    a_fail_final: assert property (@(posedge clk) disable iff (!rst_n)
        valid && failed |-> final_res && order_letter == '0)
        else $error("malformed failure result");

    // Emitted letters are spaced by the queue read, never back to back.
    a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !final_res |=> !valid)
        else $error("results closer than expected");

    // The ready queue never holds more letters than the alphabet.
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg <= lofsw_pkg::NUM_LETTERS && head_reg <= tail_reg)
        else $error("ready queue pointers out of range");

endmodule

FILE: tb/letter_order_checker.sv
`timescale 1ns / 1ps

module letter_order_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic [4:0] letter,
    input  logic       word_done,
    input  logic       list_done,
    input  logic       valid,
    input  logic [4:0] order_letter,
    input  logic       final_res,
    input  logic       failed,
    output int         fail_count,
    output int         pending
);

    typedef struct packed {
        logic [4:0] ltr;
        logic       fin;
        logic       bad;
    } order_word_t;

    order_word_t expected_order[$];

    logic [4:0] prev_word[lofsw_pkg::MAX_WORD_LEN];
    int         prev_len;
    int         pos;
    bit         diff_seen;
    bit         first_of_list;
    bit [25:0]  seen_mask;
    int         edges[lofsw_pkg::ALPHABET_SIZE][lofsw_pkg::ALPHABET_SIZE];
    int         indeg[lofsw_pkg::ALPHABET_SIZE];
    int         words_done;
    bit         list_bad;

    assign pending = expected_order.size();

    task automatic clear_model();
        prev_len      = 0;
        pos           = 0;
        diff_seen     = 0;
        first_of_list = 1;
        seen_mask     = '0;
        words_done    = 0;
        list_bad      = 0;
        for (int u = 0; u < lofsw_pkg::ALPHABET_SIZE; u++)
        begin
            indeg[u] = 0;
            for (int v = 0; v < lofsw_pkg::ALPHABET_SIZE; v++)
                edges[u][v] = 0;
        end
    endtask

    // Kahn's sort; letters freed by one pop join the queue in ascending order.
    task automatic predict_order();
        logic [4:0] ready[$];
        int         emitted;
        int         total;
        logic [4:0] u;
        order_word_t w;
        emitted = 0;
        total   = 0;
        if (!list_bad)
        begin
            for (int i = 0; i < lofsw_pkg::ALPHABET_SIZE; i++)
                if (seen_mask[i])
                begin
                    total++;
                    if (indeg[i] == 0)
                        ready = {ready, 5'(i)};
                end
            while (ready.size() > 0)
            begin
                u = ready.pop_front();
                w.ltr = u;
                w.fin = 0;
                w.bad = 0;
                expected_order = {expected_order, w};
                emitted++;
                for (int v = 0; v < lofsw_pkg::ALPHABET_SIZE; v++)
                    if (edges[u][v] != 0 && indeg[v] != 0)
                    begin
                        indeg[v] = (edges[u][v] >= indeg[v]) ? 0 : indeg[v] - edges[u][v];
                        if (indeg[v] == 0)
                            ready = {ready, 5'(v)};
                    end
            end
        end
        if (!list_bad && emitted == total && emitted > 0)
        begin
            w = expected_order.pop_back();
            w.fin = 1;
            expected_order = {expected_order, w};
        end
        else
        begin
            // Drop any partial order of a cyclic list and give the single failure word.
            repeat (emitted) void'(expected_order.pop_back());
            w.ltr = '0;
            w.fin = 1;
            w.bad = 1;
            expected_order = {expected_order, w};
        end
    endtask

    task automatic absorb_word(logic [4:0] l, logic wd, logic ld);
        if (l >= lofsw_pkg::ALPHABET_SIZE || pos >= lofsw_pkg::MAX_WORD_LEN)
            list_bad = 1;
        else
        begin
            seen_mask[l] = 1;
            if (!list_bad && !first_of_list && !diff_seen && pos < prev_len)
                if (prev_word[pos] != l)
                begin
                    edges[prev_word[pos]][l]++;
                    indeg[l]++;
                    diff_seen = 1;
                end
            prev_word[pos] = l;
            pos++;
        end
        if (wd || ld)
        begin
            if (!first_of_list && !diff_seen && prev_len > pos)
                list_bad = 1;
            if (words_done < lofsw_pkg::MAX_WORDS)
                words_done++;
            else
                list_bad = 1;
            prev_len      = pos;
            pos           = 0;
            diff_seen     = 0;
            first_of_list = 0;
        end
        if (ld)
        begin
            predict_order();
            clear_model();
        end
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        clear_model();
    end

    always @(posedge clk)
    begin
        order_word_t w;
        if (rst_n)
        begin
            if (start && !busy)
                absorb_word(letter, word_done, list_done);
            if (valid)
            begin
                if (expected_order.size() == 0)
                    report_mismatch("unexpected result, letter", order_letter, 0);
                else
                begin
                    w = expected_order.pop_front();
                    if (order_letter !== w.ltr)
                        report_mismatch("order_letter", order_letter, w.ltr);
                    if (final_res !== w.fin)
                        report_mismatch("final_res", final_res, w.fin);
                    if (failed !== w.bad)
                        report_mismatch("failed", failed, w.bad);
                end
            end
        end
    end

endmodule

FILE: tb/tb_letter_order_from_sorted_words.sv
`timescale 1ns / 1ps

module tb_letter_order_from_sorted_words;

    // The longest honest stretch without any handshake is the clearing pass
    // plus a full sort plus a long sender gap, well under this figure.
    localparam int STALL_LIMIT = 20000;
    localparam int RANDOM_WORDS_WANTED = 200;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [4:0] letter;
    logic       word_done;
    logic       list_done;
    logic       valid;
    logic [4:0] order_letter;
    logic       final_res;
    logic       failed;
    int         fail_count;
    int         pending;

    int         quiet_cycles;
    int         sent_words;

    // A scratch list: up to 12 words, each up to 40 letters.
    logic [4:0] list_buf[12][40];
    int         len_buf[12];
    int         list_size;

    letter_order_from_sorted_words dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .letter       (letter),
        .word_done    (word_done),
        .list_done    (list_done),
        .valid        (valid),
        .order_letter (order_letter),
        .final_res    (final_res),
        .failed       (failed)
    );

    letter_order_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .letter       (letter),
        .word_done    (word_done),
        .list_done    (list_done),
        .valid        (valid),
        .order_letter (order_letter),
        .final_res    (final_res),
        .failed       (failed),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // The watchdog counts cycles in which neither channel moves a word; if
    // the block hangs the run is ended as a failure.
    always @(posedge clk)
    begin
        if ((start && !busy) || valid || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one, and often none at all so
    // that back-to-back words are covered too.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    // Offers one word and holds it until the block takes it. Start stays
    // high across back-to-back words, so it is only lowered for a gap.
    task automatic send_word(logic [4:0] l, logic wd, logic ld);
        int gap;
        start     <= 1'b1;
        letter    <= l;
        word_done <= wd;
        list_done <= ld;
        do
            @(posedge clk);
        while (busy);
        sent_words++;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Streams the scratch list. With drop_end set, the last word carries
    // list_done without word_done, which must end it just the same.
    task automatic send_list(bit drop_end);
        for (int w = 0; w < list_size; w++)
            for (int i = 0; i < len_buf[w]; i++)
            begin
                if (w == list_size - 1 && i == len_buf[w] - 1)
                    send_word(list_buf[w][i], !drop_end, 1'b1);
                else
                    send_word(list_buf[w][i], i == len_buf[w] - 1, 1'b0);
            end
    endtask

    task automatic set_word(int w, string s);
        len_buf[w] = s.len();
        for (int i = 0; i < s.len(); i++)
            list_buf[w][i] = 5'(s[i] - "a");
    endtask

    // Builds a random list. When sorted is set, the words are ordered under
    // a random alphabet permutation, so a valid letter order always exists;
    // otherwise the list is left in random order and usually fails.
    task automatic build_list(bit sorted);
        int         perm[26];
        int         k;
        int         tmp;
        int         j;
        int         t_len;
        logic [4:0] t_word[40];
        bit         less;
        k         = $urandom_range(2, 26);
        list_size = $urandom_range(1, 12);
        for (int i = 0; i < 26; i++)
            perm[i] = i;
        for (int i = 25; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        for (int w = 0; w < list_size; w++)
        begin
            len_buf[w] = ($urandom_range(0, 29) == 0) ? $urandom_range(31, 36)
                                                      : $urandom_range(1, 5);
            for (int i = 0; i < len_buf[w]; i++)
                list_buf[w][i] = 5'($urandom_range(0, k - 1));
        end
        if (sorted)
        begin
            // Insertion sort on ranks; a prefix sorts before its extension.
            for (int a = 1; a < list_size; a++)
            begin
                t_len = len_buf[a];
                t_word = list_buf[a];
                j = a - 1;
                while (j >= 0)
                begin
                    less = (t_len < len_buf[j]);
                    for (int i = 0; i < 40; i++)
                        if (i < t_len && i < len_buf[j] && t_word[i] != list_buf[j][i])
                        begin
                            less = (t_word[i] < list_buf[j][i]);
                            break;
                        end
                    if (!less)
                        break;
                    list_buf[j + 1] = list_buf[j];
                    len_buf[j + 1] = len_buf[j];
                    j--;
                end
                list_buf[j + 1] = t_word;
                len_buf[j + 1] = t_len;
            end
        end
        for (int w = 0; w < list_size; w++)
            for (int i = 0; i < len_buf[w]; i++)
                list_buf[w][i] = 5'(perm[list_buf[w][i]]);
    endtask

    initial
    begin
        bit drop_end;
        rst_n        = 1'b0;
        start        = 1'b0;
        letter       = '0;
        word_done    = 1'b0;
        list_done    = 1'b0;
        sent_words   = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lists. A plain two-word list gives one edge.
        list_size = 2;
        set_word(0, "a");
        set_word(1, "z");
        send_list(0);
        // A word followed by its own prefix has no valid order.
        set_word(0, "ab");
        set_word(1, "a");
        send_list(0);
        // Three words that close a cycle between two letters.
        list_size = 3;
        set_word(0, "ab");
        set_word(1, "b");
        set_word(2, "a");
        send_list(0);
        // A single-letter list, ended by list_done alone.
        list_size = 1;
        set_word(0, "m");
        send_list(1);
        // A letter beyond the alphabet, the top code of the field.
        list_size = 2;
        set_word(0, "a");
        len_buf[1] = 2;
        list_buf[1][0] = 5'd1;
        list_buf[1][1] = 5'd31;
        send_list(0);

        // Random lists: mostly well formed, the rest unsorted or broken.
        // Word lengths sometimes pass the length limit.
        while (sent_words < RANDOM_WORDS_WANTED)
        begin
            build_list($urandom_range(0, 3) != 0);
            drop_end = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0)
                list_buf[$urandom_range(0, list_size - 1)][0] = 5'($urandom_range(26, 31));
            send_list(drop_end);
        end

        start <= 1'b0;
        // One edge so that the checker has taken the last word.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        // Let the clearing pass finish before the verdict.
        repeat (1200) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: letter_order_from_sorted_words.f
hdl/lofsw_pkg.sv
hdl/lofsw_ram.sv
hdl/letter_order_from_sorted_words.sv
tb/letter_order_checker.sv
tb/tb_letter_order_from_sorted_words.sv
